[hdl/aesc_pkg.sv]
package aesc_pkg;

    localparam int KEY_HALF_WORDS = 30;
    localparam int KEY_ROWS       = KEY_HALF_WORDS / 2;
    localparam int ROW_W          = $clog2(KEY_ROWS);
    localparam int KEY_IDX_W      = 5;

    localparam logic [3:0] MAX_ROUNDS = 4'(KEY_ROWS - 1);
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    localparam logic [1:0] FUNC_KEY   = 2'd0;
    localparam logic [1:0] FUNC_CTR   = 2'd1;
    localparam logic [1:0] FUNC_BLOCK = 2'd2;

    localparam logic REG_ROUND_COUNT = 1'b0;
    localparam logic [3:0] ROUND_COUNT_RESET = 4'd10;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_INIT,
        SEQ_ROUND,
        SEQ_OUT
    } seq_state_t;

    typedef struct packed {
        logic                 en;
        logic [KEY_IDX_W-1:0] idx;
        logic [63:0]          hi;
        logic [63:0]          lo;
    } key_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

[hdl/aesc_key_store.sv]
module aesc_key_store (
    input  logic                          aclk,
    input  aesc_pkg::key_wr_t             wr,
    input  logic [aesc_pkg::ROW_W-1:0]    rd_row,
    output logic [127:0]                  rd_key
);

    logic [63:0] even_bank [aesc_pkg::KEY_ROWS];
    logic [63:0] odd_bank  [aesc_pkg::KEY_ROWS];
    logic [63:0] even_q_reg;
    logic [63:0] odd_q_reg;
    logic        wr_in_range;

    assign wr_in_range = wr.idx < aesc_pkg::KEY_IDX_W'(aesc_pkg::KEY_HALF_WORDS);

    always_ff @(posedge aclk) begin
        if (wr.en && wr_in_range) begin
            if (wr.idx[0]) begin
                odd_bank[wr.idx[aesc_pkg::ROW_W:1]] <= wr.lo;
            end else begin
                even_bank[wr.idx[aesc_pkg::ROW_W:1]] <= wr.hi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        even_q_reg <= even_bank[rd_row];
        odd_q_reg  <= odd_bank[rd_row];
    end

    assign rd_key = {even_q_reg, odd_q_reg};

endmodule

[hdl/aesc_round.sv]
module aesc_round (
    input  logic [127:0] blk,
    input  logic [127:0] round_key,
    input  logic         final_round,
    output logic [127:0] result
);

    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    logic [7:0] hsum [4];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[i] = aesc_pkg::SBOX[blk[127 - 8 * i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[r + 4 * c] = sb[r + 4 * ((c + r) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            hsum[c] = sr[4 * c] ^ sr[4 * c + 1] ^ sr[4 * c + 2] ^ sr[4 * c + 3];
            for (int r = 0; r < 4; r++) begin
                mc[4 * c + r] = sr[4 * c + r] ^ hsum[c]
                              ^ aesc_pkg::gf_double(sr[4 * c + r] ^ sr[4 * c + ((r + 1) % 4)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            result[127 - 8 * i -: 8] = (final_round ? sr[i] : mc[i]) ^ round_key[127 - 8 * i -: 8];
        end
    end

endmodule

[hdl/aes_ctr_keystream_xor.sv]
// AES counter-mode engine with externally supplied round keys.
// The input channel (s_valid/s_ready) carries one command per transfer, chosen
// by s_func: write one 64-bit round-key half, load the 128-bit counter block, or
// process one data block. Only a processed block produces a transfer on the
// result channel (m_valid/m_ready); the other commands complete when accepted.
// A processed block passes from the accept cycle through the initial key
// addition, then through the rounds in turn in the single shared round unit,
// and then to the output step. The round-key store is read one row per round.
// A block with a byte count of zero skips the rounds and returns zeros.
// The input channel is not ready while a block is being processed. A finished
// result waits in the output register; if the receiver stalls, the engine holds
// the next finished block until the register is free and accepts no command
// meanwhile. With the receiver ready, the next command is accepted in the cycle
// after the result is loaded. The round count is written over the APB-style
// port; the user must do so only while the engine is idle, which the block
// does not enforce. Reset clears the counter, the round count (to ten) and the
// control state; the key store must be written before use.
module aes_ctr_keystream_xor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_func,
    input  logic [4:0]   s_key_index,
    input  logic [63:0]  s_word_hi,
    input  logic [63:0]  s_word_lo,
    input  logic [4:0]   s_byte_count,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  m_out_hi,
    output logic [63:0]  m_out_lo,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    aesc_pkg::seq_state_t fsm_reg, fsm_next;

    logic [3:0]   round_count_reg;
    logic [3:0]   nr_reg, nr_next;
    logic [3:0]   round_reg, round_next;
    logic [4:0]   count_reg, count_next;
    logic [63:0]  ctr_hi_reg, ctr_hi_next;
    logic [63:0]  ctr_lo_reg, ctr_lo_next;
    logic [63:0]  data_hi_reg, data_hi_next;
    logic [63:0]  data_lo_reg, data_lo_next;
    logic [127:0] blk_reg, blk_next;
    logic [127:0] res_reg, res_next;
    logic         m_valid_reg, m_valid_next;

    logic [aesc_pkg::ROW_W-1:0] rd_row;
    logic [127:0]               rd_key;
    logic [127:0]               round_out;
    logic                       final_round;
    aesc_pkg::key_wr_t          key_wr;
    logic                       s_accept;
    logic [4:0]                 count_sat;
    logic [3:0]                 nr_sat;
    logic [127:0]               ks_xor;
    logic [127:0]               out_word;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == aesc_pkg::REG_ROUND_COUNT);
    assign prdata = (paddr[2] == aesc_pkg::REG_ROUND_COUNT) ? {28'd0, round_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_count_reg <= aesc_pkg::ROUND_COUNT_RESET;
        end else if (cfg_wr) begin
            round_count_reg <= pwdata[3:0];
        end
    end

    assign s_ready  = (fsm_reg == aesc_pkg::SEQ_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_out_hi = res_reg[127:64];
    assign m_out_lo = res_reg[63:0];

    assign count_sat = (s_byte_count > aesc_pkg::BLOCK_BYTES) ? aesc_pkg::BLOCK_BYTES
                                                              : s_byte_count;
    assign nr_sat    = (round_count_reg > aesc_pkg::MAX_ROUNDS) ? aesc_pkg::MAX_ROUNDS
                                                                : round_count_reg;

    assign key_wr.en  = s_accept && (s_func == aesc_pkg::FUNC_KEY);
    assign key_wr.idx = s_key_index;
    assign key_wr.hi  = s_word_hi;
    assign key_wr.lo  = s_word_lo;

    assign final_round = (round_reg == nr_reg);

    aesc_key_store u_key_store (
        .aclk   (aclk),
        .wr     (key_wr),
        .rd_row (rd_row),
        .rd_key (rd_key)
    );

    aesc_round u_round (
        .blk         (blk_reg),
        .round_key   (rd_key),
        .final_round (final_round),
        .result      (round_out)
    );

    assign ks_xor = {data_hi_reg, data_lo_reg} ^ blk_reg;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            out_word[127 - 8 * i -: 8] = (5'(i) < count_reg) ? ks_xor[127 - 8 * i -: 8]
                                                             : 8'h00;
        end
    end

    always_comb begin
        fsm_next     = fsm_reg;
        nr_next      = nr_reg;
        round_next   = round_reg;
        count_next   = count_reg;
        ctr_hi_next  = ctr_hi_reg;
        ctr_lo_next  = ctr_lo_reg;
        data_hi_next = data_hi_reg;
        data_lo_next = data_lo_reg;
        blk_next     = blk_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rd_row       = '0;
        unique case (fsm_reg)
            aesc_pkg::SEQ_IDLE: begin
                if (s_valid) begin
                    unique case (s_func)
                        aesc_pkg::FUNC_CTR: begin
                            ctr_hi_next = s_word_hi;
                            ctr_lo_next = s_word_lo;
                        end
                        aesc_pkg::FUNC_BLOCK: begin
                            data_hi_next = s_word_hi;
                            data_lo_next = s_word_lo;
                            count_next   = count_sat;
                            nr_next      = nr_sat;
                            fsm_next     = (count_sat == 5'd0) ? aesc_pkg::SEQ_OUT
                                                               : aesc_pkg::SEQ_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            aesc_pkg::SEQ_INIT: begin
                blk_next   = {ctr_hi_reg, ctr_lo_reg} ^ rd_key;
                round_next = 4'd1;
                rd_row     = aesc_pkg::ROW_W'(1);
                fsm_next   = (nr_reg == 4'd0) ? aesc_pkg::SEQ_OUT : aesc_pkg::SEQ_ROUND;
            end
            aesc_pkg::SEQ_ROUND: begin
                blk_next   = round_out;
                round_next = round_reg + 4'd1;
                if (final_round) begin
                    fsm_next = aesc_pkg::SEQ_OUT;
                end else begin
                    rd_row = aesc_pkg::ROW_W'(round_reg + 4'd1);
                end
            end
            aesc_pkg::SEQ_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    res_next     = out_word;
                    m_valid_next = 1'b1;
                    fsm_next     = aesc_pkg::SEQ_IDLE;
                    if (count_reg != 5'd0) begin
                        ctr_lo_next = {ctr_lo_reg[63:32], ctr_lo_reg[31:0] + 32'd1};
                    end
                end
            end
            default: begin
                fsm_next = aesc_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= aesc_pkg::SEQ_IDLE;
            m_valid_reg <= 1'b0;
            ctr_hi_reg  <= '0;
            ctr_lo_reg  <= '0;
            round_reg   <= '0;
            nr_reg      <= '0;
            count_reg   <= '0;
        end else begin
            fsm_reg     <= fsm_next;
            m_valid_reg <= m_valid_next;
            ctr_hi_reg  <= ctr_hi_next;
            ctr_lo_reg  <= ctr_lo_next;
            round_reg   <= round_next;
            nr_reg      <= nr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_hi_reg <= data_hi_next;
        data_lo_reg <= data_lo_next;
        blk_reg     <= blk_next;
        res_reg     <= res_next;
    end

endmodule

[tb/sv/tb_aes_ctr_keystream_xor.sv]
`timescale 1ns / 1ps

module tb_aes_ctr_keystream_xor;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 20;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [1:0]   s_func = aesc_pkg::FUNC_KEY;
    logic [4:0]   s_key_index = '0;
    logic [63:0]  s_word_hi = '0;
    logic [63:0]  s_word_lo = '0;
    logic [4:0]   s_byte_count = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [63:0]  m_out_hi;
    logic [63:0]  m_out_lo;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic [7:0]   sub_byte [256];
    logic [63:0]  key_half [aesc_pkg::KEY_HALF_WORDS];
    logic [127:0] counter_block = '0;
    logic [3:0]   round_setting = aesc_pkg::ROUND_COUNT_RESET;
    logic [127:0] pending_blocks [$];
    logic [127:0] checked_block;
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           stall_left = 0;

    aes_ctr_keystream_xor dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_key_index  (s_key_index),
        .s_word_hi    (s_word_hi),
        .s_word_lo    (s_word_lo),
        .s_byte_count (s_byte_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_hi     (m_out_hi),
        .m_out_lo     (m_out_lo),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] gf_times2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) begin
                p = p ^ a;
            end
            a = gf_times2(a);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [127:0] encrypt_counter_block(input logic [127:0] ctr, input int nr);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, h;
        logic [127:0] rk;
        logic [127:0] res;
        rk = {key_half[0], key_half[1]};
        for (int i = 0; i < 16; i++) begin
            s[i] = ctr[127 - 8 * i -: 8] ^ rk[127 - 8 * i -: 8];
        end
        for (int r = 1; r <= nr; r++) begin
            for (int i = 0; i < 16; i++) begin
                t[i] = sub_byte[s[i]];
            end
            for (int i = 0; i < 16; i++) begin
                s[i] = t[4 * (((i / 4) + (i % 4)) % 4) + (i % 4)];
            end
            if (r != nr) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c];
                    a1 = s[4 * c + 1];
                    a2 = s[4 * c + 2];
                    a3 = s[4 * c + 3];
                    h = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ h ^ gf_times2(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ h ^ gf_times2(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ h ^ gf_times2(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ h ^ gf_times2(a3 ^ a0);
                end
            end
            rk = {key_half[2 * r], key_half[2 * r + 1]};
            for (int i = 0; i < 16; i++) begin
                s[i] = s[i] ^ rk[127 - 8 * i -: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = s[i];
        end
        return res;
    endfunction

    task automatic predict_command(input logic [1:0] func, input logic [4:0] idx,
                                   input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [4:0] cnt);
        int           n;
        int           nr;
        logic [127:0] res;
        case (func)
            aesc_pkg::FUNC_KEY: begin
                if (idx < aesc_pkg::KEY_HALF_WORDS) begin
                    key_half[idx] = idx[0] ? lo : hi;
                end
            end
            aesc_pkg::FUNC_CTR: begin
                counter_block = {hi, lo};
            end
            aesc_pkg::FUNC_BLOCK: begin
                n = (cnt > 5'd16) ? 16 : int'(cnt);
                if (n == 0) begin
                    pending_blocks.push_back('0);
                end else begin
                    nr = (round_setting > aesc_pkg::KEY_HALF_WORDS / 2 - 1) ?
                         aesc_pkg::KEY_HALF_WORDS / 2 - 1 : int'(round_setting);
                    res = {hi, lo} ^ encrypt_counter_block(counter_block, nr);
                    for (int i = n; i < 16; i++) begin
                        res[127 - 8 * i -: 8] = 8'h00;
                    end
                    pending_blocks.push_back(res);
                    counter_block[31:0] = counter_block[31:0] + 32'd1;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_command(input logic [1:0] func, input logic [4:0] idx,
                                input logic [63:0] hi, input logic [63:0] lo,
                                input logic [4:0] cnt);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_func = func;
        s_key_index = idx;
        s_word_hi = hi;
        s_word_lo = lo;
        s_byte_count = cnt;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_command(func, idx, hi, lo, cnt);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] cnt);
        send_command(aesc_pkg::FUNC_BLOCK, 5'($urandom), hi, lo, cnt);
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_blocks.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_round_count(input logic [3:0] value);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(4 * aesc_pkg::REG_ROUND_COUNT);
        pwdata = {28'($urandom), value};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        round_setting = value;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_random_commands(input int count);
        int          sent;
        int          pick;
        logic [1:0]  func;
        logic [4:0]  idx;
        logic [63:0] hi, lo;
        logic [4:0]  cnt;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            idx = 5'($urandom);
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            cnt = 5'd16;
            if (pick < 8) begin
                func = aesc_pkg::FUNC_KEY;
            end else if (pick < 16) begin
                func = aesc_pkg::FUNC_CTR;
                if ($urandom_range(3) == 0) begin
                    lo[31:0] = 32'hffff_fff0 | 32'($urandom_range(15));
                end
            end else if (pick < 20) begin
                func = FUNC_UNUSED;
            end else begin
                func = aesc_pkg::FUNC_BLOCK;
                if ($urandom_range(3) == 0) begin
                    cnt = 5'($urandom_range(31));
                end
            end
            send_command(func, idx, hi, lo, cnt);
            if (!(func == FUNC_UNUSED ||
                  (func == aesc_pkg::FUNC_KEY && idx >= aesc_pkg::KEY_HALF_WORDS))) begin
                sent++;
            end
        end
    endtask

    task automatic test_key_store_load();
        for (int i = 0; i < aesc_pkg::KEY_HALF_WORDS; i++) begin
            send_command(aesc_pkg::FUNC_KEY, 5'(i), {$urandom, $urandom},
                         {$urandom, $urandom}, 5'($urandom));
        end
        // Writes beyond the store and the unused command must leave everything untouched.
        send_command(aesc_pkg::FUNC_KEY, 5'd30, '1, '1, 5'd16);
        send_command(aesc_pkg::FUNC_KEY, 5'd31, '1, '1, 5'd16);
        send_command(FUNC_UNUSED, 5'd0, '1, '1, 5'd16);
        send_command(aesc_pkg::FUNC_KEY, 5'd0, '1, '0, 5'd0);
        send_command(aesc_pkg::FUNC_KEY, 5'd1, '0, '1, 5'd31);
    endtask

    task automatic test_block_edges();
        send_command(aesc_pkg::FUNC_CTR, 5'd0, '0, '0, 5'd0);
        send_block('0, '0, 5'd16);
        send_block('1, '1, 5'd16);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd15);
        send_block('1, '1, 5'd0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
        send_block('1, '1, 5'd17);
        send_block('1, '1, 5'd31);
        // The low word wraps without carrying into the upper bytes.
        send_command(aesc_pkg::FUNC_CTR, 5'd0, '1, '1, 5'd16);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd8);
        wait_until_drained();
    endtask

    task automatic test_round_counts();
        logic [3:0] settings [6];
        settings = '{4'd0, 4'd1, 4'd15, 4'd14, 4'd12, 4'd10};
        for (int i = 0; i < 6; i++) begin
            write_round_count(settings[i]);
            send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
            send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(1, 16)));
            wait_until_drained();
        end
    endtask

    task automatic test_backpressure();
        stall_left = 300;
        for (int i = 0; i < 12; i++) begin
            send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
            if (i % 4 == 1) begin
                send_command(aesc_pkg::FUNC_KEY,
                             5'($urandom_range(aesc_pkg::KEY_HALF_WORDS - 1)),
                             {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
            end
            if (i == 6) begin
                send_command(aesc_pkg::FUNC_CTR, 5'd0, {$urandom, $urandom},
                             {$urandom, $urandom}, 5'd16);
            end
        end
        wait_until_drained();
        for (int i = 0; i < 6; i++) begin
            send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
        end
        wait_until_drained();
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 13;
        recv_idle_pct = 47;
        write_round_count(4'd10);
        send_random_commands(215);
        wait_until_drained();
        send_idle_pct = 47;
        recv_idle_pct = 13;
        write_round_count(4'd14);
        send_random_commands(215);
        wait_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_round_count(4'($urandom_range(15)));
        send_random_commands(215);
        wait_until_drained();
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result transfer, out_hi %h out_lo %h",
                         $time, m_out_hi, m_out_lo);
                error_count++;
            end else begin
                checked_block = pending_blocks.pop_front();
                if (m_out_hi !== checked_block[127:64]) begin
                    $display("%0t: out_hi mismatch, expected %h actual %h",
                             $time, checked_block[127:64], m_out_hi);
                    error_count++;
                end
                if (m_out_lo !== checked_block[63:0]) begin
                    $display("%0t: out_lo mismatch, expected %h actual %h",
                             $time, checked_block[63:0], m_out_lo);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [7:0] inv;
        for (int v = 0; v < 256; v++) begin
            inv = 8'd1;
            for (int e = 0; e < 254; e++) begin
                inv = gf_mul(inv, 8'(v));
            end
            sub_byte[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
        send_idle_pct = 13;
        recv_idle_pct = 47;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        write_round_count(aesc_pkg::ROUND_COUNT_RESET);
        test_key_store_load();
        test_block_edges();
        test_round_counts();
        test_backpressure();
        test_random_traffic();
        wait_until_drained();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/aesc_pkg.sv
hdl/aesc_key_store.sv
hdl/aesc_round.sv
hdl/aes_ctr_keystream_xor.sv
tb/sv/tb_aes_ctr_keystream_xor.sv
